// ===== rtl/ipat_pkg.sv =====
// Shared types and constants for the IP address to text converter.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ipat_pkg;

    // Address family codes as they arrive on the request channel.
    localparam logic [1:0] FAM_IPV4 = 2'd0;
    localparam logic [1:0] FAM_IPV6 = 2'd1;

    // Characters that the formatter produces.
    localparam logic [7:0] CH_NUL         = 8'h00;
    localparam logic [7:0] CH_COLON       = 8'h3a;
    localparam logic [7:0] CH_DOT         = 8'h2e;
    localparam logic [7:0] CH_ZERO        = 8'h30;
    localparam logic [7:0] CH_NINE        = 8'h39;
    localparam logic [7:0] CH_LOWER_A     = 8'h61;
    localparam logic [7:0] CH_LOWER_F     = 8'h66;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'h57;

    // Depth of the descriptor queue between the classifier and the formatter.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]  family;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } in_item_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
        logic       bad_family;
    } out_item_t;

    // How the formatter has to write an address.
    typedef enum logic [2:0] {
        MODE_V4,
        MODE_V6_HEX,
        MODE_V6_V4,
        MODE_V6_FFFF,
        MODE_BAD
    } mode_t;

    // One classified address: the eight groups (IPv4 sits in the lowest two)
    // and the first longest run of zero groups.
    typedef struct packed {
        mode_t        mode;
        logic [127:0] groups;
        logic [2:0]   run_start;
        logic [3:0]   run_len;
    } desc_t;

endpackage

`default_nettype wire

// ===== rtl/ipat_front.sv =====
// Front end: takes address requests, registers them and classifies them.
// Finds the first longest zero-group run and the output mode; uses ipat_pkg.
`default_nettype none

module ipat_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire ipat_pkg::in_item_t s_data,
    output logic                  q_push,
    output ipat_pkg::desc_t       q_data,
    input  wire logic             q_full
);
    import ipat_pkg::*;

    logic     item_valid_reg;
    in_item_t item_reg;

    logic [127:0] addr;
    logic [7:0]   zero;
    logic [3:0]   cur_len;
    logic [3:0]   best_len;
    logic [2:0]   best_start;
    logic [3:0]   start_calc;
    logic         mapped;

    assign s_ready = !item_valid_reg || !q_full;
    assign q_push  = item_valid_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_ready) begin
            item_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
    end

    assign addr = {item_reg.addr_high, item_reg.addr_low};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            zero[i] = (addr[127 - 16*i -: 16] == 16'h0000);
        end
    end

    // Scan the eight groups in order; a later run must be strictly longer
    // to win, so the first of equally long runs is kept.
    always_comb begin
        cur_len    = 4'd0;
        best_len   = 4'd0;
        best_start = 3'd0;
        start_calc = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (zero[i]) begin
                cur_len = cur_len + 4'd1;
                if (cur_len > best_len) begin
                    best_len   = cur_len;
                    start_calc = 4'(i) + 4'd1 - cur_len;
                    best_start = start_calc[2:0];
                end
            end else begin
                cur_len = 4'd0;
            end
        end
    end

    assign mapped = (best_start == 3'd0) &&
                    ((best_len == 4'd6) ||
                     ((best_len == 4'd5) && (addr[47:32] == 16'hffff)));

    always_comb begin
        q_data.groups    = addr;
        q_data.run_start = best_start;
        q_data.run_len   = best_len;
        unique case (item_reg.family)
            FAM_IPV4: begin
                q_data.mode = MODE_V4;
            end
            FAM_IPV6: begin
                if (mapped) begin
                    q_data.mode = (best_len == 4'd6) ? MODE_V6_V4 : MODE_V6_FFFF;
                end else begin
                    q_data.mode = MODE_V6_HEX;
                end
            end
            default: begin
                q_data.mode = MODE_BAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/ipat_queue.sv =====
// Short descriptor queue between the classifier and the formatter.
// Register-based, one write and one read port; uses ipat_pkg.
`default_nettype none

module ipat_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire ipat_pkg::desc_t wr_data,
    output logic                 full,
    input  wire logic            pop,
    output ipat_pkg::desc_t      rd_data,
    output logic                 empty
);
    import ipat_pkg::*;

    desc_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QPTR_W:0]   CNT_FULL = (QPTR_W + 1)'(QUEUE_DEPTH);

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ipat_back.sv =====
// Back end: walks one classified address and emits its text, one character
// per cycle unless stalled, through an output register. Uses ipat_pkg.
`default_nettype none

module ipat_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_empty,
    output logic                 q_pop,
    input  wire ipat_pkg::desc_t q_data,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output ipat_pkg::out_item_t  m_data
);
    import ipat_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_PFX     = 9'b000000010,
        ST_HEX_DIG = 9'b000000100,
        ST_HEX_COL = 9'b000001000,
        ST_DCOL1   = 9'b000010000,
        ST_DCOL2   = 9'b000100000,
        ST_DEC     = 9'b001000000,
        ST_DOT     = 9'b010000000,
        ST_BAD     = 9'b100000000
    } state_t;

    // Positions within "::ffff:" at which each mapped prefix ends.
    localparam logic [2:0] PFX_LAST_V4   = 3'd1;
    localparam logic [2:0] PFX_LAST_FFFF = 3'd6;
    localparam logic [2:0] PFX_FFFF_COL  = 3'd6;
    localparam logic [2:0] GRP_LAST      = 3'd7;
    localparam logic [1:0] OCT_LAST      = 2'd3;

    state_t     state_reg, state_next;
    desc_t      desc_reg, desc_next;
    logic [2:0] grp_idx_reg, grp_idx_next;
    logic [1:0] nib_reg, nib_next;
    logic [1:0] octet_reg, octet_next;
    logic [1:0] digit_reg, digit_next;
    logic [2:0] pfx_pos_reg, pfx_pos_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_data_reg, m_data_next;

    logic        adv;
    logic [15:0] cur_group;
    logic [3:0]  cur_nibble;
    logic [3:0]  run_end;
    logic [2:0]  tgt;
    logic [15:0] tgt_group;
    logic        tgt_dcol;
    logic [7:0]  cur_oct;
    logic [7:0]  nxt_oct;
    logic [1:0]  nxt_octet_idx;
    logic [1:0]  dig_h;
    logic [7:0]  dig_r;
    logic [15:0] dig_prod;
    logic [3:0]  dig_t;
    logic [7:0]  dig_u;
    logic [3:0]  cur_digit;

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + {4'b0000, n} : HEX_ALPHA_BASE + {4'b0000, n};
    endfunction

    // Index of the first nibble to print: leading zeros are dropped.
    function automatic logic [1:0] lead_nib(input logic [15:0] g);
        logic [1:0] r;
        if (g[15:12] != 4'h0) begin
            r = 2'd3;
        end else if (g[11:8] != 4'h0) begin
            r = 2'd2;
        end else if (g[7:4] != 4'h0) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    function automatic logic [1:0] dec_lead(input logic [7:0] v);
        logic [1:0] r;
        if (v >= 8'd100) begin
            r = 2'd2;
        end else if (v >= 8'd10) begin
            r = 2'd1;
        end else begin
            r = 2'd0;
        end
        return r;
    endfunction

    assign adv = !m_valid_reg || m_ready;

    assign cur_group  = desc_reg.groups[{~grp_idx_reg, 4'b0000} +: 16];
    assign cur_nibble = cur_group[{nib_reg, 2'b00} +: 4];
    assign run_end    = {1'b0, desc_reg.run_start} + desc_reg.run_len;

    // Group that the walk moves on to next, either after a group's digits
    // or after the double colon that replaces the zero run.
    assign tgt       = (state_reg == ST_DCOL2) ? run_end[2:0] : grp_idx_reg + 3'd1;
    assign tgt_group = desc_reg.groups[{~tgt, 4'b0000} +: 16];
    assign tgt_dcol  = (desc_reg.run_len != 4'd0) && (tgt == desc_reg.run_start);

    assign cur_oct       = desc_reg.groups[{~octet_reg, 3'b000} +: 8];
    assign nxt_octet_idx = octet_reg + 2'd1;
    assign nxt_oct       = desc_reg.groups[{~nxt_octet_idx, 3'b000} +: 8];

    // Decimal digits of one octet; the tens come from a multiply by the
    // reciprocal of ten, exact for remainders below one hundred.
    always_comb begin
        if (cur_oct >= 8'd200) begin
            dig_h = 2'd2;
            dig_r = cur_oct - 8'd200;
        end else if (cur_oct >= 8'd100) begin
            dig_h = 2'd1;
            dig_r = cur_oct - 8'd100;
        end else begin
            dig_h = 2'd0;
            dig_r = cur_oct;
        end
        dig_prod = {8'h00, dig_r} * 16'd205;
        dig_t    = dig_prod[14:11];
        dig_u    = dig_r - ({4'b0000, dig_t} * 8'd10);
        unique case (digit_reg)
            2'd2:    cur_digit = {2'b00, dig_h};
            2'd1:    cur_digit = dig_t;
            default: cur_digit = dig_u[3:0];
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        desc_next    = desc_reg;
        grp_idx_next = grp_idx_reg;
        nib_next     = nib_reg;
        octet_next   = octet_reg;
        digit_next   = digit_reg;
        pfx_pos_next = pfx_pos_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;

        if (adv) begin
            m_data_next.last_char  = 1'b0;
            m_data_next.bad_family = 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        q_pop        = 1'b1;
                        desc_next    = q_data;
                        grp_idx_next = 3'd0;
                        octet_next   = 2'd0;
                        pfx_pos_next = 3'd0;
                        digit_next   = dec_lead(q_data.groups[31:24]);
                        nib_next     = lead_nib(q_data.groups[127:112]);
                        unique case (q_data.mode)
                            MODE_V4: begin
                                state_next = ST_DEC;
                            end
                            MODE_V6_HEX: begin
                                if ((q_data.run_len != 4'd0) &&
                                    (q_data.run_start == 3'd0)) begin
                                    state_next = ST_DCOL1;
                                end else begin
                                    state_next = ST_HEX_DIG;
                                end
                            end
                            MODE_V6_V4, MODE_V6_FFFF: begin
                                state_next = ST_PFX;
                            end
                            default: begin
                                state_next = ST_BAD;
                            end
                        endcase
                    end
                end
                ST_PFX: begin
                    m_valid_next = 1'b1;
                    m_data_next.text_char =
                        ((pfx_pos_reg < 3'd2) || (pfx_pos_reg == PFX_FFFF_COL)) ?
                        CH_COLON : CH_LOWER_F;
                    if (pfx_pos_reg == ((desc_reg.mode == MODE_V6_V4) ?
                                        PFX_LAST_V4 : PFX_LAST_FFFF)) begin
                        state_next = ST_DEC;
                    end else begin
                        pfx_pos_next = pfx_pos_reg + 3'd1;
                    end
                end
                ST_HEX_DIG: begin
                    m_valid_next          = 1'b1;
                    m_data_next.text_char = hex_char(cur_nibble);
                    if (nib_reg != 2'd0) begin
                        nib_next = nib_reg - 2'd1;
                    end else if (grp_idx_reg == GRP_LAST) begin
                        m_data_next.last_char = 1'b1;
                        state_next            = ST_IDLE;
                    end else if (tgt_dcol) begin
                        // The zero run follows: its double colon stands in
                        // for the separator.
                        grp_idx_next = tgt;
                        state_next   = ST_DCOL1;
                    end else begin
                        state_next = ST_HEX_COL;
                    end
                end
                ST_HEX_COL: begin
                    m_valid_next          = 1'b1;
                    m_data_next.text_char = CH_COLON;
                    grp_idx_next          = tgt;
                    nib_next              = lead_nib(tgt_group);
                    state_next            = tgt_dcol ? ST_DCOL1 : ST_HEX_DIG;
                end
                ST_DCOL1: begin
                    m_valid_next          = 1'b1;
                    m_data_next.text_char = CH_COLON;
                    state_next            = ST_DCOL2;
                end
                ST_DCOL2: begin
                    m_valid_next          = 1'b1;
                    m_data_next.text_char = CH_COLON;
                    if (run_end[3]) begin
                        m_data_next.last_char = 1'b1;
                        state_next            = ST_IDLE;
                    end else begin
                        grp_idx_next = tgt;
                        nib_next     = lead_nib(tgt_group);
                        state_next   = ST_HEX_DIG;
                    end
                end
                ST_DEC: begin
                    m_valid_next          = 1'b1;
                    m_data_next.text_char = CH_ZERO + {4'b0000, cur_digit};
                    if (digit_reg != 2'd0) begin
                        digit_next = digit_reg - 2'd1;
                    end else if (octet_reg == OCT_LAST) begin
                        m_data_next.last_char = 1'b1;
                        state_next            = ST_IDLE;
                    end else begin
                        state_next = ST_DOT;
                    end
                end
                ST_DOT: begin
                    m_valid_next          = 1'b1;
                    m_data_next.text_char = CH_DOT;
                    octet_next            = nxt_octet_idx;
                    digit_next            = dec_lead(nxt_oct);
                    state_next            = ST_DEC;
                end
                ST_BAD: begin
                    m_valid_next           = 1'b1;
                    m_data_next.text_char  = CH_NUL;
                    m_data_next.last_char  = 1'b1;
                    m_data_next.bad_family = 1'b1;
                    state_next             = ST_IDLE;
                end
                default: begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg    <= desc_next;
        grp_idx_reg <= grp_idx_next;
        nib_reg     <= nib_next;
        octet_reg   <= octet_next;
        digit_reg   <= digit_next;
        pfx_pos_reg <= pfx_pos_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/ip_address_to_text.sv =====
// IP address to text converter, top level.
// Joins the classifier, the descriptor queue and the formatter; uses ipat_pkg.
//
// A request on the s_ channel carries a family code and a 128-bit address
// (IPv4 in the lowest 32 bits). The m_ channel returns the text form as a
// run of ASCII characters, one per transfer, with last_char set on the final
// one. IPv6 is written in compressed lowercase hex, with the mapped forms
// ::a.b.c.d and ::ffff:a.b.c.d; an unknown family gives a single character
// 0 with bad_family and last_char set.
// An address passes the input register, the queue, the formatter load and
// the output register. The formatter loads an address and then writes one
// character per cycle while the receiver takes them, up to 39 characters
// per address; it loads the next address only after the last character of
// the current one, so that character walk sets the sustained rate.
// Up to four classified addresses wait in the queue, so requests keep being
// taken while the receiver stalls; the output register holds its character
// until taken, and the input side stalls once the queue and the input
// register are both full. Reset clears the queue, the formatter and the
// output valid; no memory needs clearing.
`default_nettype none

module ip_address_to_text (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ipat_pkg::in_item_t s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ipat_pkg::out_item_t     m_data
);
    import ipat_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    desc_t q_wr_data;
    desc_t q_rd_data;

    ipat_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_push  (q_push),
        .q_data  (q_wr_data),
        .q_full  (q_full)
    );

    ipat_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    ipat_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_data  (q_rd_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== rtl/ipat_checker.sv =====
// Port-level checks for the IP address to text converter, bound to the top.
// Sees only the top-level ports; uses ipat_pkg.
`default_nettype none

module ipat_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire ipat_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ipat_pkg::out_item_t m_data
);
    import ipat_pkg::*;

    // A stalled character must be held as it is.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A waiting request stays offered, unchanged, until it is taken.
    a_req_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // Nothing is offered straight after reset.
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    // The error result is a single NUL that ends its address.
    a_bad_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.bad_family |-> m_data.last_char && (m_data.text_char == CH_NUL))
        else $error("malformed error result");

    // Address text uses only digits, lowercase hex letters, colons and dots.
    a_charset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.bad_family |->
            ((m_data.text_char >= CH_ZERO) && (m_data.text_char <= CH_NINE)) ||
            ((m_data.text_char >= CH_LOWER_A) && (m_data.text_char <= CH_LOWER_F)) ||
            (m_data.text_char == CH_COLON) || (m_data.text_char == CH_DOT))
        else $error("unexpected character in address text");

endmodule

bind ip_address_to_text ipat_checker u_ipat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
